### design/pcmx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmx_pkg: shared types and codes for the PCM channel mixer
// Source format codes, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package pcmx_pkg;

    localparam int unsigned GAIN_W    = 9;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        OP_MONO8    = 2'd0,
        OP_STEREO8  = 2'd1,
        OP_MONO16   = 2'd2,
        OP_STEREO16 = 2'd3
    } t_op;

    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_SIXTEEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_STEREO    = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 9'd256;

    typedef enum logic [2:0] {
        S_IDLE,
        S_L_VOL,
        S_L_GAIN,
        S_R_VOL,
        S_R_GAIN,
        S_EMIT_L,
        S_EMIT_R
    } t_state;

endpackage

### design/pcmx_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmx_in_if: voice request channel
// One voice sample pair with its volumes and the frame marker.
// ----------------------------------------------------------------------------
interface pcmx_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  operation;
    logic signed [15:0] sample_left;
    logic signed [15:0] sample_right;
    logic        [7:0]  left_volume;
    logic        [7:0]  right_volume;
    logic        [7:0]  voice_volume;
    logic               end_of_frame;

    modport source (
        output valid, operation, sample_left, sample_right,
               left_volume, right_volume, voice_volume, end_of_frame,
        input  ready
    );
    modport sink (
        input  valid, operation, sample_left, sample_right,
               left_volume, right_volume, voice_volume, end_of_frame,
        output ready
    );
endinterface

### design/pcmx_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmx_out_if: mixed sample channel
// One saturated output sample with its side and frame-end flags.
// ----------------------------------------------------------------------------
interface pcmx_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample_out;
    logic        right_side;
    logic        last_of_frame;

    modport source (
        output valid, sample_out, right_side, last_of_frame,
        input  ready
    );
    modport sink (
        input  valid, sample_out, right_side, last_of_frame,
        output ready
    );
endinterface

### design/pcm_channel_mixer_clip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_channel_mixer_clip: saturating PCM voice mixer
// Accumulates voices into left/right sums and emits clipped frame samples.
// ----------------------------------------------------------------------------
// Each voice request is taken only while the sequencer is idle. A voice with a
// nonzero side volume then uses the single shared 26x10 signed multiplier in
// S_L_VOL, S_L_GAIN, S_R_VOL and S_R_GAIN: sample times volume, then that
// product times master gain, once for the left side and once for the right;
// the next request is taken only back in idle. A silent voice skips the
// multiplier. A request that closes the frame then emits one output sample
// per side (two in stereo, one in mono), held while the output sink stalls;
// a one-entry output register lets the last sample wait while the next voice
// is taken. The accumulators wrap modulo 2^32 and clear after each frame.
module pcm_channel_mixer_clip
    import pcmx_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [GAIN_W-1:0]    i_cfg_data,
    pcmx_in_if.sink              i_in,
    pcmx_out_if.source           o_out
);

    t_state r_state, n_state;

    logic [GAIN_W-1:0] r_gain;
    logic              r_out_sixteen;
    logic              r_out_stereo;

    // latched request
    t_op         r_op;
    logic [15:0] r_sl;
    logic [15:0] r_sr;
    logic [7:0]  r_lv;
    logic [7:0]  r_rv;
    logic [7:0]  r_vv;
    logic        r_eof;

    logic signed [25:0] r_prod;
    logic [31:0]        r_left_sum;
    logic [31:0]        r_right_sum;

    logic        r_ov;
    logic [15:0] r_sample_out;
    logic        r_right_side;
    logic        r_last;

    logic               w_accept;
    logic               w_slot;
    logic               w_is8;
    logic               w_stereo_src;
    logic signed [16:0] w_sample;
    logic [7:0]         w_vol;
    logic signed [25:0] w_mul_a;
    logic signed [9:0]  w_mul_b;
    logic signed [35:0] w_mul_p;
    logic [31:0]        w_add;
    logic [31:0]        w_acc_in;
    logic [31:0]        w_acc_sum;
    logic [31:0]        w_emit_src;
    logic [15:0]        w_emit_val;
    logic               w_load;
    logic               w_done;

    function automatic logic signed [16:0] fmt_sample(input logic [15:0] raw,
                                                      input logic is8);
        if (is8) begin
            return {{9{~raw[7]}}, ~raw[7], raw[6:0]};
        end
        return {raw[15], raw};
    endfunction

    function automatic logic [15:0] clip_emit(input logic [31:0] sum,
                                              input logic sixteen);
        logic [23:0] sh;
        logic [15:0] c;
        sh = sum[31:8];
        if (sh[23:15] == {9{sh[23]}}) begin
            c = sh[15:0];
        end else if (sh[23]) begin
            c = 16'h8000;
        end else begin
            c = 16'h7FFF;
        end
        if (sixteen) begin
            return c;
        end
        return {8'h00, ~c[15], c[14:8]};
    endfunction

    assign w_accept     = i_in.valid && i_in.ready;
    assign w_slot       = !r_ov || o_out.ready;
    assign w_is8        = (r_op == OP_MONO8) || (r_op == OP_STEREO8);
    assign w_stereo_src = (r_op == OP_STEREO8) || (r_op == OP_STEREO16);

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_ov;
    assign o_out.sample_out    = r_sample_out;
    assign o_out.right_side    = r_right_side;
    assign o_out.last_of_frame = r_last;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if ((i_in.left_volume != 8'd0) || (i_in.right_volume != 8'd0)) begin
                        n_state = S_L_VOL;
                    end else if (i_in.end_of_frame) begin
                        n_state = S_EMIT_L;
                    end
                end
            end
            S_L_VOL:  n_state = S_L_GAIN;
            S_L_GAIN: n_state = S_R_VOL;
            S_R_VOL:  n_state = S_R_GAIN;
            S_R_GAIN: n_state = r_eof ? S_EMIT_L : S_IDLE;
            S_EMIT_L: begin
                if (w_slot) begin
                    n_state = r_out_stereo ? S_EMIT_R : S_IDLE;
                end
            end
            S_EMIT_R: begin
                if (w_slot) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        w_sample   = fmt_sample(r_sl, w_is8);
        w_vol      = r_lv;
        w_mul_a    = r_prod;
        w_mul_b    = {1'b0, r_gain};
        w_acc_in   = r_right_sum;
        w_emit_src = r_left_sum;
        w_load     = 1'b0;
        w_done     = 1'b0;
        unique case (r_state)
            S_L_VOL: begin
                w_sample = fmt_sample(r_sl, w_is8);
                w_vol    = w_stereo_src ? r_vv : r_lv;
            end
            S_R_VOL: begin
                w_sample = fmt_sample(w_stereo_src ? r_sr : r_sl, w_is8);
                w_vol    = w_stereo_src ? r_vv : r_rv;
            end
            S_L_GAIN: begin
                w_acc_in = r_left_sum;
            end
            S_EMIT_L: begin
                w_load = w_slot;
                w_done = w_slot && !r_out_stereo;
            end
            S_EMIT_R: begin
                w_emit_src = r_right_sum;
                w_load     = w_slot;
                w_done     = w_slot;
            end
            default: begin
            end
        endcase
        if ((r_state == S_L_VOL) || (r_state == S_R_VOL)) begin
            w_mul_a = {{9{w_sample[16]}}, w_sample};
            w_mul_b = {2'b00, w_is8 ? {w_vol[7:3], 3'b000} : w_vol};
        end
    end

    assign w_mul_p    = w_mul_a * w_mul_b;
    // 16-bit sources drop eight fraction bits (floor), 8-bit ones keep all
    assign w_add      = w_is8 ? w_mul_p[31:0] : {{4{w_mul_p[35]}}, w_mul_p[35:8]};
    assign w_acc_sum  = w_acc_in + w_add;
    assign w_emit_val = clip_emit(w_emit_src, r_out_sixteen);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_gain        <= GAIN_RESET;
            r_out_sixteen <= 1'b1;
            r_out_stereo  <= 1'b1;
            r_left_sum    <= '0;
            r_right_sum   <= '0;
            r_ov          <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MASTER_GAIN: r_gain        <= i_cfg_data;
                    CFG_OUT_SIXTEEN: r_out_sixteen <= i_cfg_data[0];
                    CFG_OUT_STEREO:  r_out_stereo  <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (r_state == S_L_GAIN) begin
                r_left_sum <= w_acc_sum;
            end
            if (r_state == S_R_GAIN) begin
                r_right_sum <= w_acc_sum;
            end
            // clear both sums once the frame's last sample is loaded
            if (w_done) begin
                r_left_sum  <= '0;
                r_right_sum <= '0;
            end
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= t_op'(i_in.operation);
            r_sl  <= i_in.sample_left;
            r_sr  <= i_in.sample_right;
            r_lv  <= i_in.left_volume;
            r_rv  <= i_in.right_volume;
            r_vv  <= i_in.voice_volume;
            r_eof <= i_in.end_of_frame;
        end
        if ((r_state == S_L_VOL) || (r_state == S_R_VOL)) begin
            r_prod <= w_mul_p[25:0];
        end
        if (w_load) begin
            r_sample_out <= w_emit_val;
            r_right_side <= (r_state == S_EMIT_R);
            r_last       <= w_done;
        end
    end

    a_loud_voice_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && ((i_in.left_volume != 8'd0) || (i_in.right_volume != 8'd0))
        |=> r_state == S_L_VOL)
        else $error("non-silent voice did not start the multiply sequence");

    a_left_then_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_L_GAIN |=> r_state == S_R_VOL)
        else $error("right side did not follow left side");

    a_frame_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> (r_left_sum == 32'd0) && (r_right_sum == 32'd0))
        else $error("accumulators not cleared after frame");

    a_right_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.right_side |-> o_out.last_of_frame)
        else $error("right sample not flagged as frame end");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_in.ready || (r_state == S_IDLE))
        else $error("request taken while sequencer busy");

endmodule

### bench/tb_pcm_channel_mixer_clip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pcm_channel_mixer_clip: self-checking bench for the PCM channel mixer
// Drives voice requests and register writes, predicts every mixed frame
// sample and compares it field by field with what the mixer emits.
// ----------------------------------------------------------------------------
module tb_pcm_channel_mixer_clip
    import pcmx_pkg::*;
();

    localparam int              CYCLE_LIMIT  = 1_000_000;
    localparam int              DRAIN_CYCLES = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        t_op                operation;
        logic signed [15:0] sample_left;
        logic signed [15:0] sample_right;
        logic        [7:0]  left_volume;
        logic        [7:0]  right_volume;
        logic        [7:0]  voice_volume;
        logic               end_of_frame;
    } t_voice;

    typedef struct {
        logic [15:0] sample_out;
        logic        right_side;
        logic        last_of_frame;
    } t_mix_sample;

    class mix_scoreboard;
        logic [GAIN_W-1:0] gain;
        bit                sixteen;
        bit                stereo;
        logic [31:0]       left_acc;
        logic [31:0]       right_acc;
        t_mix_sample       frame_q[$];
        int                mismatches;

        function new();
            gain       = GAIN_RESET;
            sixteen    = 1'b1;
            stereo     = 1'b1;
            left_acc   = '0;
            right_acc  = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
            unique case (idx)
                CFG_MASTER_GAIN: gain    = data;
                CFG_OUT_SIXTEEN: sixteen = data[0];
                CFG_OUT_STEREO:  stereo  = data[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return frame_q.size();
        endfunction

        function longint scaled8(logic [15:0] raw, logic [7:0] vol);
            longint s;
            s = longint'(raw[7:0]) - 128;
            return s * longint'(vol >> 3) * 8 * longint'(gain);
        endfunction

        function longint scaled16(logic signed [15:0] smp, logic [7:0] vol);
            longint p;
            p = longint'(smp) * longint'(vol) * longint'(gain);
            return p >>> 8;
        endfunction

        function logic [15:0] to_out(logic [31:0] acc);
            longint v;
            logic [7:0] b;
            v = longint'($signed(acc)) >>> 8;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            if (sixteen) return v[15:0];
            b = 8'((v >>> 8) + 128);
            return {8'h00, b};
        endfunction

        function void note_request(t_voice v);
            longint      add_l;
            longint      add_r;
            t_mix_sample r;
            add_l = 0;
            add_r = 0;
            // silent voice: both side volumes zero adds nothing, any format
            if (v.left_volume != 0 || v.right_volume != 0) begin
                unique case (v.operation)
                    OP_MONO8: begin
                        add_l = scaled8(v.sample_left, v.left_volume);
                        add_r = scaled8(v.sample_left, v.right_volume);
                    end
                    OP_STEREO8: begin
                        add_l = scaled8(v.sample_left, v.voice_volume);
                        add_r = scaled8(v.sample_right, v.voice_volume);
                    end
                    OP_MONO16: begin
                        add_l = scaled16(v.sample_left, v.left_volume);
                        add_r = scaled16(v.sample_left, v.right_volume);
                    end
                    default: begin
                        add_l = scaled16(v.sample_left, v.voice_volume);
                        add_r = scaled16(v.sample_right, v.voice_volume);
                    end
                endcase
                left_acc  = left_acc + add_l[31:0];
                right_acc = right_acc + add_r[31:0];
            end
            if (v.end_of_frame) begin
                r.sample_out    = to_out(left_acc);
                r.right_side    = 1'b0;
                r.last_of_frame = !stereo;
                frame_q.push_back(r);
                if (stereo) begin
                    r.sample_out    = to_out(right_acc);
                    r.right_side    = 1'b1;
                    r.last_of_frame = 1'b1;
                    frame_q.push_back(r);
                end
                left_acc  = '0;
                right_acc = '0;
            end
        endfunction

        function void report(string what, logic [15:0] want, logic [15:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h got %h", what, want, got);
        endfunction

        function void check_sample(t_mix_sample got);
            t_mix_sample want;
            if (frame_q.size() == 0) begin
                report("unexpected sample", 16'h0, got.sample_out);
                return;
            end
            want = frame_q.pop_front();
            if (got.sample_out !== want.sample_out)
                report("sample_out", want.sample_out, got.sample_out);
            if (got.right_side !== want.right_side)
                report("right_side", 16'(want.right_side), 16'(got.right_side));
            if (got.last_of_frame !== want.last_of_frame)
                report("last_of_frame", 16'(want.last_of_frame), 16'(got.last_of_frame));
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [GAIN_W-1:0] i_cfg_data;

    pcmx_in_if  v_in ();
    pcmx_out_if s_out ();

    pcm_channel_mixer_clip u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (v_in),
        .o_out       (s_out)
    );

    mix_scoreboard sb = new();
    bit            no_idle      = 1'b0;
    int            hold_request = 0;
    int            cycle_count  = 0;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (no_idle || r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [15:0] pick_sample();
        unique case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'($signed($urandom_range(0, 8)) - 4);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [7:0] pick_volume();
        unique case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_voice make_voice(t_op op, logic signed [15:0] sl,
                                          logic signed [15:0] sr, logic [7:0] lv,
                                          logic [7:0] rv, logic [7:0] vv, logic eof);
        t_voice v;
        v.operation    = op;
        v.sample_left  = sl;
        v.sample_right = sr;
        v.left_volume  = lv;
        v.right_volume = rv;
        v.voice_volume = vv;
        v.end_of_frame = eof;
        return v;
    endfunction

    function automatic t_voice random_voice(int eof_one_in);
        t_voice v;
        v = make_voice(t_op'($urandom_range(0, 3)), pick_sample(), pick_sample(),
                       pick_volume(), pick_volume(), pick_volume(),
                       $urandom_range(1, eof_one_in) == 1);
        if ($urandom_range(0, 9) == 0) begin
            v.left_volume  = 8'd0;
            v.right_volume = 8'd0;
        end
        return v;
    endfunction

    // Called right after a rising edge; leaves valid high after acceptance.
    task automatic send_voice(t_voice v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            v_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        v_in.valid        <= 1'b1;
        v_in.operation    <= v.operation;
        v_in.sample_left  <= v.sample_left;
        v_in.sample_right <= v.sample_right;
        v_in.left_volume  <= v.left_volume;
        v_in.right_volume <= v.right_volume;
        v_in.voice_volume <= v.voice_volume;
        v_in.end_of_frame <= v.end_of_frame;
        do @(posedge i_clk); while (!v_in.ready);
        sb.note_request(v);
    endtask

    task automatic run_random(int count, int eof_one_in);
        repeat (count) send_voice(random_voice(eof_one_in));
        v_in.valid <= 1'b0;
    endtask

    // Always wait for a clock edge first so the next drive lands in a new step.
    task automatic wait_drained();
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    // Write only with the mixer idle: drain the results, then let a
    // request with no frame end finish its multiply passes.
    task automatic apply_config(logic [GAIN_W-1:0] gain, bit sixteen, bit stereo);
        logic [GAIN_W-1:0] d;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(CFG_MASTER_GAIN, gain);
        d    = GAIN_W'($urandom_range(0, 511));
        d[0] = sixteen;
        write_reg(CFG_OUT_SIXTEEN, d);
        d    = GAIN_W'($urandom_range(0, 511));
        d[0] = stereo;
        write_reg(CFG_OUT_STEREO, d);
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_UNUSED, GAIN_W'($urandom_range(0, 511)));
        i_cfg_we <= 1'b0;
    endtask

    // Result side: check at the edge, then pick ready for the next cycle.
    initial begin : sample_sink
        int          stall_left;
        int          hold_left;
        t_mix_sample got;
        stall_left  = 0;
        hold_left   = 0;
        s_out.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (s_out.valid === 1'b1 && s_out.ready === 1'b1) begin
                got.sample_out    = s_out.sample_out;
                got.right_side    = s_out.right_side;
                got.last_of_frame = s_out.last_of_frame;
                sb.check_sample(got);
            end
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                s_out.ready <= 1'b0;
            end else if (no_idle) begin
                s_out.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                s_out.ready <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left  = pick_gap();
                s_out.ready <= 1'b0;
            end else begin
                s_out.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = '0;
        i_cfg_data        = '0;
        v_in.valid        = 1'b0;
        v_in.operation    = OP_MONO8;
        v_in.sample_left  = '0;
        v_in.sample_right = '0;
        v_in.left_volume  = '0;
        v_in.right_volume = '0;
        v_in.voice_volume = '0;
        v_in.end_of_frame = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, every format, extremes, silent voices
        send_voice(make_voice(OP_MONO8, 16'sh00FF, 16'sh0000, 8'd255, 8'd255, 8'd0, 1'b0));
        send_voice(make_voice(OP_MONO8, 16'shFF00, 16'sh7FFF, 8'd255, 8'd7, 8'd255, 1'b1));
        send_voice(make_voice(OP_STEREO8, 16'sh0080, 16'shFF7F, 8'd1, 8'd0, 8'd255, 1'b1));
        send_voice(make_voice(OP_MONO16, 16'sh7FFF, 16'sh8000, 8'd255, 8'd0, 8'd0, 1'b1));
        send_voice(make_voice(OP_MONO16, 16'sh8000, 16'sh7FFF, 8'd255, 8'd255, 8'd0, 1'b1));
        send_voice(make_voice(OP_STEREO16, -16'sd1, 16'sd1, 8'd0, 8'd1, 8'd1, 1'b1));
        send_voice(make_voice(OP_STEREO16, 16'sh7FFF, 16'sh8000, 8'd0, 8'd0, 8'd255, 1'b0));
        send_voice(make_voice(OP_STEREO8, 16'sh00FF, 16'sh0000, 8'd0, 8'd0, 8'd255, 1'b1));
        send_voice(make_voice(OP_STEREO16, 16'sh7FFF, 16'sh8000, 8'd255, 8'd255, 8'd255, 1'b0));
        send_voice(make_voice(OP_STEREO16, 16'sh7FFF, 16'sh8000, 8'd255, 8'd255, 8'd255, 1'b1));
        send_voice(make_voice(OP_MONO8, 16'sh0001, 16'sh0000, 8'd0, 8'd255, 8'd0, 1'b1));
        send_voice(make_voice(OP_MONO16, 16'sd3, 16'sd0, 8'd17, 8'd200, 8'd0, 1'b0));
        v_in.valid <= 1'b0;

        apply_config(9'd511, 1'b0, 1'b0);
        send_voice(make_voice(OP_MONO16, 16'sh8000, 16'sh0000, 8'd255, 8'd255, 8'd0, 1'b1));
        send_voice(make_voice(OP_MONO8, 16'sh00FF, 16'sh0000, 8'd255, 8'd8, 8'd0, 1'b1));
        send_voice(make_voice(OP_STEREO16, 16'sd300, -16'sd300, 8'd5, 8'd0, 8'd9, 1'b1));
        send_voice(make_voice(OP_STEREO8, 16'sh0000, 16'sh00FF, 8'd0, 8'd3, 8'd255, 1'b1));
        v_in.valid <= 1'b0;

        apply_config(9'd0, 1'b1, 1'b1);
        send_voice(make_voice(OP_STEREO16, 16'sh7FFF, 16'sh8000, 8'd255, 8'd255, 8'd255, 1'b1));
        v_in.valid <= 1'b0;

        // accumulator wrap: a long frame of full-scale voices at top gain
        apply_config(9'd511, 1'b1, 1'b1);
        repeat (139)
            send_voice(make_voice(OP_STEREO16, 16'sh7FFF, 16'sh8000,
                                  8'd255, 8'd255, 8'd255, 1'b0));
        send_voice(make_voice(OP_STEREO16, 16'sh7FFF, 16'sh8000,
                              8'd255, 8'd255, 8'd255, 1'b1));
        v_in.valid <= 1'b0;

        for (int phase = 0; phase < 12; phase++) begin
            unique case (phase)
                0:       apply_config(9'd511, 1'b0, 1'b1);
                1:       apply_config(9'd0, 1'b1, 1'b0);
                2:       apply_config(GAIN_RESET, 1'b1, 1'b1);
                default: apply_config(GAIN_W'($urandom_range(0, 511)),
                                      $urandom_range(0, 1), $urandom_range(0, 1));
            endcase
            no_idle = (phase == 5);
            if (phase == 3) begin
                run_random(30, 4);
                // pause until every frame sample is back, then resume
                wait_drained();
                run_random(30, 4);
            end else if (phase == 7) begin
                // hold off the sink so the output backs up and stalls requests
                apply_config(GAIN_RESET, 1'b1, 1'b1);
                hold_request = 400;
                run_random(40, 2);
            end else begin
                run_random(60, 4);
            end
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
